[sv/run_length_7f_codec_macros.svh]
// Assertion macros shared by the run-length codec RTL.
`ifndef RUN_LENGTH_7F_CODEC_MACROS_SVH
`define RUN_LENGTH_7F_CODEC_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RL7F_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RL7F_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rl7f_pkg.sv]
// Package: constants, job record and helpers for the 0x7F run-length codec.
`timescale 1ns / 1ps
package rl7f_pkg;

    localparam logic [7:0] RUN_BYTE   = 8'h7F;
    localparam logic [7:0] DIGIT_FLAG = 8'h80;
    localparam int DIGIT_BITS         = 7;
    localparam int COUNT_W            = 21;
    localparam int COUNT_DIGITS_DEF   = 3;
    localparam int QUEUE_DEPTH_DEF    = 4;

    localparam logic MODE_COMPRESS   = 1'b0;
    localparam logic MODE_DECOMPRESS = 1'b1;

    // One classified input item, as handed from the front to the back.
    typedef struct packed {
        logic [COUNT_W-1:0] run_val;  // run count to expand or emit
        logic [1:0]         n_run;    // count digits, or 1 for a decompressed run
        logic               dec;      // run results come from decompress mode
        logic               has_lit;  // a literal byte follows the run results
        logic [7:0]         lit;
        logic               last;
        logic               ovf;
    } job_t;

    // Number of base-128 digits a nonzero count needs (zero gives none).
    function automatic logic [1:0] digit_groups(input logic [COUNT_W-1:0] cnt);
        logic [1:0] g;
        begin
            if (cnt[20:14] != 7'd0)
                g = 2'd3;
            else if (cnt[13:7] != 7'd0)
                g = 2'd2;
            else if (cnt[6:0] != 7'd0)
                g = 2'd1;
            else
                g = 2'd0;
            return g;
        end
    endfunction

endpackage

[sv/run_length_7f_codec.sv]
// Top level of the 0x7F run-length codec: front, job queue and back end.
// A taken beat's job is written into the job queue; its result beats then pass through the output register.
// Throughput: one input beat per cycle while the queue has room and each beat makes at most one
// result; a beat that makes k results (k up to 4) holds the shared output register for all k of them.
// The job queue (QUEUE_DEPTH entries) absorbs digit flushes; input stalls only when it fills.
// Reset (rst_n, async low) clears mode to compress, the run state, overflow and the queue.
`timescale 1ns / 1ps
`include "run_length_7f_codec_macros.svh"
module run_length_7f_codec #(
    parameter int COUNT_DIGITS = rl7f_pkg::COUNT_DIGITS_DEF,
    parameter int QUEUE_DEPTH  = rl7f_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: one register, mode
    input  logic        mode_we,
    input  logic        mode_wdata,
    // input beat
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    // result beat
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [20:0] repeat_res,
    output logic        item_done,
    output logic        stream_end,
    output logic        overflow
);

    logic                          accept;
    logic                          push;
    rl7f_pkg::job_t                push_job;
    logic                          q_full;
    logic                          head_valid;
    rl7f_pkg::job_t                head;
    logic                          pop;
    logic [$clog2(QUEUE_DEPTH):0]  q_count;

    // Take a beat whenever the queue has room; the front updates run state on every taken beat,
    // even one that yields no result (a counted 0x7F, a digit); a mode write in that cycle clears it instead.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    rl7f_front #(
        .COUNT_DIGITS (COUNT_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .accept     (accept),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .push       (push),
        .job        (push_job)
    );

    // Hold classified jobs so the front keeps taking beats while the back
    // drains multi-digit flushes.
    rl7f_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    // Expand the head job one result beat per cycle into the output register, unless the output stalls.
    rl7f_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .repeat_res (repeat_res),
        .item_done  (item_done),
        .stream_end (stream_end),
        .overflow   (overflow)
    );

    // Stream end only ever marks the last result of an item.
    `RL7F_ASSERT_NOW(a_end_is_done, clk, rst_n, out_valid && stream_end, item_done, "stream_end without item_done")

    // Only a decompressed run carries a repeat count other than one.
    `RL7F_ASSERT_NOW(a_rep_only_run, clk, rst_n, out_valid && repeat_res != 21'd1, out_byte == rl7f_pkg::RUN_BYTE, "repeat count on a non-run byte")

    // Overflow is sticky across delivered beats.
    `RL7F_ASSERT_NEXT(a_ovf_sticky, clk, rst_n, out_valid && !out_stall && overflow, !out_valid || overflow, "overflow flag dropped")

    // The queue never holds more jobs than it has entries.
    `RL7F_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1, 32'(q_count) <= QUEUE_DEPTH, "job queue overrun")

endmodule

[sv/rl7f_front.sv]
// Front end: holds the mode and run state, classifies each beat into a job.
`timescale 1ns / 1ps
module rl7f_front #(
    parameter int COUNT_DIGITS = rl7f_pkg::COUNT_DIGITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mode_we,
    input  logic              mode_wdata,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              push,
    output rl7f_pkg::job_t    job
);

    localparam logic [20:0] CAP = (COUNT_DIGITS >= 3) ? 21'h1FFFFF
        : 21'((32'd1 << (rl7f_pkg::DIGIT_BITS * COUNT_DIGITS)) - 32'd1);

    logic        mode_reg;
    logic [20:0] run_cnt_reg, run_cnt_next;
    logic        pending_reg, pending_next;
    logic [1:0]  dig_cnt_reg, dig_cnt_next;
    logic        ovf_reg, ovf_next;

    logic        flush_en;
    logic [20:0] flush_cnt;
    logic        lit_en;
    logic [27:0] dec_next;
    logic        too_many;
    logic [1:0]  n_run;

    assign dec_next = {run_cnt_reg, data_byte[6:0]};
    assign too_many = (COUNT_DIGITS <= 3) && (32'(dig_cnt_reg) >= 32'(COUNT_DIGITS));

    always_comb
    begin
        run_cnt_next = run_cnt_reg;
        pending_next = pending_reg;
        dig_cnt_next = dig_cnt_reg;
        ovf_next     = ovf_reg;
        flush_en     = 1'b0;
        flush_cnt    = run_cnt_reg;
        lit_en       = 1'b0;

        if (mode_reg == rl7f_pkg::MODE_COMPRESS) begin
            if (data_byte == rl7f_pkg::RUN_BYTE) begin
                if (run_cnt_reg >= CAP)
                    ovf_next = 1'b1;
                else
                    run_cnt_next = run_cnt_reg + 21'd1;
                pending_next = 1'b1;
                flush_en     = last_byte;
                flush_cnt    = run_cnt_next;
            end else begin
                flush_en     = pending_reg;
                lit_en       = 1'b1;
                run_cnt_next = '0;
                pending_next = 1'b0;
                dig_cnt_next = '0;
            end
        end else begin
            if (data_byte[7]) begin
                if (too_many || dec_next > 28'(CAP)) begin
                    ovf_next     = 1'b1;
                    run_cnt_next = CAP;
                end else begin
                    run_cnt_next = dec_next[20:0];
                end
                if (dig_cnt_reg != 2'd3)
                    dig_cnt_next = dig_cnt_reg + 2'd1;
                pending_next = 1'b1;
                flush_en     = last_byte;
                flush_cnt    = run_cnt_next;
            end else begin
                flush_en     = pending_reg;
                lit_en       = 1'b1;
                run_cnt_next = '0;
                pending_next = 1'b0;
                dig_cnt_next = '0;
            end
        end

        // End of stream drops the pending run once it is flushed
        if (last_byte) begin
            run_cnt_next = '0;
            pending_next = 1'b0;
            dig_cnt_next = '0;
        end
    end

    always_comb
    begin
        n_run = 2'd0;
        if (flush_en && flush_cnt != 21'd0) begin
            if (mode_reg == rl7f_pkg::MODE_COMPRESS)
                n_run = rl7f_pkg::digit_groups(flush_cnt);
            else
                n_run = 2'd1;
        end
    end

    assign push        = accept && (n_run != 2'd0 || lit_en);
    assign job.run_val = flush_cnt;
    assign job.n_run   = n_run;
    assign job.dec     = (mode_reg == rl7f_pkg::MODE_DECOMPRESS);
    assign job.has_lit = lit_en;
    assign job.lit     = data_byte;
    assign job.last    = last_byte;
    assign job.ovf     = ovf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= rl7f_pkg::MODE_COMPRESS;
            run_cnt_reg <= '0;
            pending_reg <= 1'b0;
            dig_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
        end else if (mode_we) begin
            mode_reg    <= mode_wdata;
            run_cnt_reg <= '0;
            pending_reg <= 1'b0;
            dig_cnt_reg <= '0;
        end else if (accept) begin
            run_cnt_reg <= run_cnt_next;
            pending_reg <= pending_next;
            dig_cnt_reg <= dig_cnt_next;
            ovf_reg     <= ovf_next;
        end
    end

endmodule

[sv/rl7f_queue.sv]
// Job queue between the front and the back of the codec.
`timescale 1ns / 1ps
module rl7f_queue #(
    parameter int DEPTH = rl7f_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  rl7f_pkg::job_t           push_job,
    input  logic                     pop,
    output logic                     full,
    output logic                     head_valid,
    output rl7f_pkg::job_t           head,
    output logic [$clog2(DEPTH):0]   count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0]        PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0]        PTR_ONE  = PTR_W'(1);
    localparam logic [$clog2(DEPTH):0]  CNT_FULL = ($clog2(DEPTH) + 1)'(DEPTH);
    localparam logic [$clog2(DEPTH):0]  CNT_ONE  = ($clog2(DEPTH) + 1)'(1);

    rl7f_pkg::job_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [$clog2(DEPTH):0]   cnt_reg;
    logic                     do_push, do_pop;

    assign full       = (cnt_reg == CNT_FULL);
    assign head_valid = (cnt_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign count      = cnt_reg;
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + CNT_ONE;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - CNT_ONE;
        end
    end

endmodule

[sv/rl7f_back.sv]
// Back end: expands the head job into result beats through an output register.
`timescale 1ns / 1ps
module rl7f_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  rl7f_pkg::job_t    head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic [20:0]       repeat_res,
    output logic              item_done,
    output logic              stream_end,
    output logic              overflow
);

    logic        valid_reg;
    logic [7:0]  byte_reg;
    logic [20:0] rep_reg;
    logic        done_reg, end_reg, ovf_reg;
    logic [1:0]  idx_reg;

    logic        emit, last_res;
    logic [2:0]  total;
    logic [1:0]  di;
    logic [6:0]  grp;
    logic [7:0]  res_byte;
    logic [20:0] res_rep;

    assign total    = {1'b0, head.n_run} + {2'b00, head.has_lit};
    assign last_res = ({1'b0, idx_reg} == total - 3'd1);
    assign emit     = head_valid && (!valid_reg || !out_stall);
    assign pop      = emit && last_res;
    assign di       = head.n_run - 2'd1 - idx_reg;

    always_comb
    begin
        case (di)
            2'd0:    grp = head.run_val[6:0];
            2'd1:    grp = head.run_val[13:7];
            2'd2:    grp = head.run_val[20:14];
            default: grp = 7'd0;
        endcase
    end

    always_comb
    begin
        res_byte = head.lit;
        res_rep  = 21'd1;
        if (idx_reg < head.n_run) begin
            if (head.dec) begin
                res_byte = rl7f_pkg::RUN_BYTE;
                res_rep  = head.run_val;
            end else begin
                res_byte = rl7f_pkg::DIGIT_FLAG | {1'b0, grp};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            byte_reg <= res_byte;
            rep_reg  <= res_rep;
            done_reg <= last_res;
            end_reg  <= last_res && head.last;
            ovf_reg  <= head.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (emit)
                valid_reg <= 1'b1;
            else if (!out_stall)
                valid_reg <= 1'b0;
            if (emit)
                idx_reg <= last_res ? 2'd0 : idx_reg + 2'd1;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign repeat_res = rep_reg;
    assign item_done  = done_reg;
    assign stream_end = end_reg;
    assign overflow   = ovf_reg;

endmodule
